@@ hdl/lrukv_pkg.sv @@
// Package for the LRU key/value cache: shared constants, default parameter
// values and the operation code type.
// No dependencies.
package lrukv_pkg;

  // Default number of entries and of stored key bits.
  localparam int unsigned ENTRIES_DEF  = 16;
  localparam int unsigned KEY_BITS_DEF = 32;

  // Fixed field widths of the streaming interface.
  localparam int unsigned KEY_IN_W = 32;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned CAP_W    = 5;

  // Capacity register value after reset.
  localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

  // Operation carried in the input tuser bit.
  typedef enum logic {
    KIND_GET = 1'b0,
    KIND_PUT = 1'b1
  } kind_e;

endpackage

@@ hdl/lru_key_value_cache.sv @@
// Top level of the fully associative LRU key/value cache.
// Depends on lrukv_pkg for constants and the operation code type.
//
// The cache holds up to ENTRIES key/value pairs in flip-flops and takes one
// get or put transaction per clock cycle, sustained as long as results are
// taken when presented. An accepted transaction first lands in an input
// register; once the result register is empty or is being emptied, the key
// is compared against every entry in parallel, the recency ranks are
// updated, and the single result is written into the output register. The
// parallel key compare across all entries and the rank adjustment of every
// entry happen together in the lookup and update stage, between the input
// register and the output register. Each entry keeps a recency rank, 0
// being the most recent
// and count-1 the least recent; a hit or a replacement moves the entry to
// rank 0 and ages the entries that were more recent, an insertion into a
// free slot ages all valid entries. The output register frees the input
// side from the output side: a new transaction is accepted while a result
// still waits, as long as that result is taken in the same cycle the next
// one is produced. The capacity register limits how many entries are used
// before the least recent one is replaced; zero behaves as one and values
// above ENTRIES behave as ENTRIES. Lowering it below the current fill
// evicts nothing, later inserts simply replace the least recent entry.
// Configuration writes are always accepted and are meant to happen only
// while no transaction is in flight. Valid bits and ranks clear at reset;
// keys and data are not reset, since they are read only from valid entries.
module lru_key_value_cache #(
  parameter int unsigned ENTRIES  = lrukv_pkg::ENTRIES_DEF,  // 1 to 256
  parameter int unsigned KEY_BITS = lrukv_pkg::KEY_BITS_DEF  // 4 to 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  // Configuration: the capacity register.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lrukv_pkg::CAP_W-1:0]    cfg_data_i,

  // Input stream.
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // tdata: key [31:0], value [63:32]
  input  logic [lrukv_pkg::KEY_IN_W+lrukv_pkg::DATA_W-1:0] s_axis_tdata_i,
  // tuser: kind [0] (0 get, 1 put)
  input  logic [0:0]                     s_axis_tuser_i,

  // Result stream.
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // tdata: read_value [31:0]
  output logic [lrukv_pkg::DATA_W-1:0]   m_axis_tdata_o,
  // tuser: hit [0]
  output logic [0:0]                     m_axis_tuser_o
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned RANK_W = IDX_W;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > lrukv_pkg::CAP_W) ? CNT_W : lrukv_pkg::CAP_W;
  localparam int unsigned DATA_W = lrukv_pkg::DATA_W;
  localparam int unsigned KEY_IN_W = lrukv_pkg::KEY_IN_W;

  // ---------------------------------------------------------------------
  // Configuration register.
  // ---------------------------------------------------------------------
  logic [lrukv_pkg::CAP_W-1:0] capacity_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= lrukv_pkg::CAPACITY_RESET;
    end else if (cfg_valid_i) begin
      capacity_q <= cfg_data_i;
    end
  end

  // Capacity clamped to the range one to ENTRIES.
  logic [CNT_W-1:0] eff_cap;

  always_comb begin
    if (capacity_q == '0) begin
      eff_cap = CNT_W'(1);
    end else if (CMP_W'(capacity_q) > CMP_W'(ENTRIES)) begin
      eff_cap = CNT_W'(ENTRIES);
    end else begin
      eff_cap = CNT_W'(capacity_q);
    end
  end

  // ---------------------------------------------------------------------
  // Input register.
  // ---------------------------------------------------------------------
  logic [KEY_BITS-1:0] key_in;

  // Only the low KEY_BITS bits of the key take part; a wider store
  // zero-extends the incoming key.
  if (KEY_BITS <= KEY_IN_W) begin : g_key_narrow
    assign key_in = s_axis_tdata_i[KEY_BITS-1:0];
  end else begin : g_key_wide
    assign key_in = {{(KEY_BITS-KEY_IN_W){1'b0}}, s_axis_tdata_i[KEY_IN_W-1:0]};
  end

  logic                    in_valid_q;
  lrukv_pkg::kind_e        in_kind_q;
  logic [KEY_BITS-1:0]     in_key_q;
  logic [DATA_W-1:0]       in_value_q;
  logic                    proceed;
  logic                    in_accept;

  // The lookup stage moves on when the result register is empty or is
  // being emptied in this cycle.
  assign proceed         = in_valid_q && (!m_axis_tvalid_o || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || proceed;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_kind_q  <= lrukv_pkg::kind_e'(s_axis_tuser_i[0]);
      in_key_q   <= key_in;
      in_value_q <= s_axis_tdata_i[KEY_IN_W+DATA_W-1:KEY_IN_W];
    end
  end

  // ---------------------------------------------------------------------
  // Entry storage.
  // ---------------------------------------------------------------------
  logic [KEY_BITS-1:0] entry_key_q  [ENTRIES];
  logic [DATA_W-1:0]   entry_data_q [ENTRIES];
  logic [ENTRIES-1:0]  valid_q, valid_d;
  logic [RANK_W-1:0]   rank_q [ENTRIES];
  logic [RANK_W-1:0]   rank_d [ENTRIES];
  logic [CNT_W-1:0]    count_q, count_d;

  // ---------------------------------------------------------------------
  // Lookup and update.
  // ---------------------------------------------------------------------
  logic [ENTRIES-1:0] match;
  logic               hit;
  logic [IDX_W-1:0]   found_idx;
  logic [IDX_W-1:0]   free_idx;
  logic [IDX_W-1:0]   victim_idx;
  logic [RANK_W-1:0]  last_rank;

  assign last_rank = RANK_W'(count_q - CNT_W'(1));

  always_comb begin
    found_idx  = '0;
    free_idx   = '0;
    victim_idx = '0;
    // Walk downward so the lowest qualifying index wins.
    for (int j = ENTRIES - 1; j >= 0; j--) begin
      match[j] = valid_q[j] && (entry_key_q[j] == in_key_q);
      if (match[j]) begin
        found_idx = IDX_W'(j);
      end
      if (!valid_q[j]) begin
        free_idx = IDX_W'(j);
      end
      // Ranks of valid entries are a permutation of 0 to count-1, so the
      // least recent entry is the one holding the last rank.
      if (valid_q[j] && rank_q[j] == last_rank) begin
        victim_idx = IDX_W'(j);
      end
    end
  end

  assign hit = |match;

  logic               do_insert;   // put miss with a free slot under capacity
  logic               do_touch;    // entry becomes most recent, more recent ones age
  logic [IDX_W-1:0]   touch_idx;
  logic [RANK_W-1:0]  touch_rank;
  logic               wr_key;
  logic               wr_data;
  logic [IDX_W-1:0]   wr_idx;

  always_comb begin
    do_insert  = 1'b0;
    do_touch   = 1'b0;
    touch_idx  = found_idx;
    touch_rank = rank_q[found_idx];
    wr_key     = 1'b0;
    wr_data    = 1'b0;
    wr_idx     = found_idx;
    if (proceed) begin
      priority if (hit) begin
        do_touch = 1'b1;
        wr_data  = (in_kind_q == lrukv_pkg::KIND_PUT);
      end else if (in_kind_q == lrukv_pkg::KIND_PUT) begin
        if (count_q < eff_cap && !(&valid_q)) begin
          do_insert = 1'b1;
          wr_idx    = free_idx;
        end else begin
          do_touch   = 1'b1;
          touch_idx  = victim_idx;
          touch_rank = last_rank;
          wr_idx     = victim_idx;
        end
        wr_key  = 1'b1;
        wr_data = 1'b1;
      end else begin
        // Get miss: state is left alone.
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    count_d = count_q;
    for (int j = 0; j < ENTRIES; j++) begin
      rank_d[j] = rank_q[j];
      if (do_touch) begin
        if (IDX_W'(j) == touch_idx) begin
          rank_d[j] = '0;
        end else if (valid_q[j] && rank_q[j] < touch_rank) begin
          rank_d[j] = rank_q[j] + RANK_W'(1);
        end
      end else if (do_insert) begin
        if (IDX_W'(j) == wr_idx) begin
          rank_d[j]  = '0;
          valid_d[j] = 1'b1;
        end else if (valid_q[j]) begin
          rank_d[j] = rank_q[j] + RANK_W'(1);
        end
      end
    end
    if (do_insert) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      for (int j = 0; j < ENTRIES; j++) begin
        rank_q[j] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
      for (int j = 0; j < ENTRIES; j++) begin
        rank_q[j] <= rank_d[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_key) begin
      entry_key_q[wr_idx] <= in_key_q;
    end
    if (wr_data) begin
      entry_data_q[wr_idx] <= in_value_q;
    end
  end

  // ---------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------
  logic              out_valid_q;
  logic              out_hit_q;
  logic [DATA_W-1:0] out_data_q;
  logic [DATA_W-1:0] out_data_d;

  assign out_data_d = (hit && in_kind_q == lrukv_pkg::KIND_GET) ?
                      entry_data_q[found_idx] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proceed) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proceed) begin
      out_hit_q  <= hit;
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = out_data_q;
  assign m_axis_tuser_o[0] = out_hit_q;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
`ifndef ASSERT_OFF
  // The fill count always equals the number of valid entries.
  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(count_q))
    else $error("fill count does not match valid entries");

  // A key is never stored in two valid entries.
  a_unique_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match))
    else $error("key found in more than one entry");

  // Every transaction leaving the lookup stage shows up as a result.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proceed |=> m_axis_tvalid_o)
    else $error("lookup stage advanced without producing a result");

  // An insertion only happens below the capacity and into a free slot.
  a_insert_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_insert |-> (count_q < eff_cap) && !valid_q[free_idx])
    else $error("insertion into an occupied slot or beyond capacity");
`endif

endmodule
